FILE: hw/rtl/tqi_pkg.sv
`default_nettype none
package tqi_pkg;
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = 5;
  localparam int VAL_W = 32;
  localparam int NUM_W = 100;   // |f|*|p|*|q| < 2^31*2^33*2^33
  localparam int DEN_W = 66;    // |r|*|s| < 2^33*2^33
  localparam int QUO_W = 100;
  localparam int ACC_W = 104;

  localparam logic FN_WRITE = 1'b0;
  localparam logic FN_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FEW = 2'd1, ST_SAT = 2'd2, ST_REP = 2'd3
  } status_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;
endpackage
`default_nettype wire

FILE: hw/rtl/tqi_table_ram.sv
`default_nettype none
module tqi_table_ram (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [tqi_pkg::IDX_W-1:0] wr_addr,
  input  wire logic [tqi_pkg::VAL_W-1:0] wr_abs,
  input  wire logic [tqi_pkg::VAL_W-1:0] wr_ord,
  input  wire logic [tqi_pkg::IDX_W-1:0] rd_addr,
  output logic      [tqi_pkg::VAL_W-1:0] rd_abs,
  output logic      [tqi_pkg::VAL_W-1:0] rd_ord
);
  import tqi_pkg::*;
  logic [2*VAL_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {wr_abs, wr_ord};
    {rd_abs, rd_ord} <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/tqi_divider.sv
`default_nettype none
module tqi_divider (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire tqi_pkg::div_req_t         req,
  output logic                           done,
  output logic      [tqi_pkg::QUO_W-1:0] quo
);
  import tqi_pkg::*;
  // restoring divide, one quotient bit per cycle, round half up on magnitudes
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_r, rem_nxt, sh;
  logic [QUO_W-1:0] q_r, q_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic             run_r, run_nxt, done_r, done_nxt;
  logic [DEN_W+1:0] r2;

  always_comb begin
    num_nxt = num_r; rem_nxt = rem_r; q_nxt = q_r; cnt_nxt = cnt_r;
    run_nxt = run_r; done_nxt = 1'b0;
    sh = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
    r2 = {rem_r, 1'b0};
    if (start) begin
      num_nxt = req.num; rem_nxt = '0; q_nxt = '0;
      cnt_nxt = 7'(NUM_W); run_nxt = 1'b1;
    end else if (run_r) begin
      if (cnt_r != 7'd0) begin
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
        if (sh >= {1'b0, den_r}) begin
          rem_nxt = sh - {1'b0, den_r};
          q_nxt = {q_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = sh;
          q_nxt = {q_r[QUO_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
      end else begin
        if (r2 >= {2'b0, den_r}) q_nxt = q_r + QUO_W'(1);
        run_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; done_r <= 1'b0;
    end else begin
      run_r <= run_nxt; done_r <= done_nxt;
    end
    num_r <= num_nxt; rem_r <= rem_nxt; q_r <= q_nxt; cnt_r <= cnt_nxt;
    if (start) den_r <= req.den;
  end

  assign done = done_r;
  assign quo = q_r;
endmodule
`default_nettype wire

FILE: hw/rtl/table_quadratic_interpolator_unit.sv
`default_nettype none
// Channel | Direction | Handshake          | Payload
// in      | in        | start & !busy      | in_func, in_entry_index, in_abscissa_value,
//         |           |                    | in_ordinate_value, in_query_x
// out     | out       | out_valid (1 cycle)| out_result_value, out_status
// cfg     | in        | cfg_valid&cfg_ready| cfg_data (points_in_use)
// A write item and a too-few query pass through S_OUT before the next accept.
// A query reads both table ends, runs the binary search through the table RAM
// (up to 4 probes; an exact hit ends it), reads the triple, then per term forms
// products on one 33x33 multiplier, starts the shared bit-serial divider, waits
// for the rounded quotient and adds; saturation and the result strobe follow.
// Synchronous active-low reset clears control; the table is undefined until written.
// Results are strobed for one cycle; the receiver cannot stall.
module table_quadratic_interpolator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_func,
  input  wire logic [3:0]  in_entry_index,
  input  wire logic signed [31:0] in_abscissa_value,
  input  wire logic signed [31:0] in_ordinate_value,
  input  wire logic signed [31:0] in_query_x,
  output logic             out_valid,
  output logic signed [31:0] out_result_value,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);
  import tqi_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_LO    = 12'b000000000010,  // entry 0 back, read entry n-1
    S_HI    = 12'b000000000100,  // entry n-1 back
    S_PROBE = 12'b000000001000,  // read mid
    S_PWAIT = 12'b000000010000,  // mid back
    S_TRIP  = 12'b000000100000,  // read triple entries
    S_MUL   = 12'b000001000000,  // one product per cycle
    S_DIV   = 12'b000010000000,
    S_DWAIT = 12'b000100000000,
    S_SUM   = 12'b001000000000,
    S_SAT   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh8000_0000);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] piu_r;
  logic [CNT_W-1:0] n;
  assign n = (piu_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : piu_r;

  logic signed [31:0] x_r;
  logic [IDX_W-1:0] k1_r, k2_r, rd_addr, mid;
  logic [1:0] ti_r;                 // triple / term counter
  logic signed [31:0] b_r [3];
  logic signed [31:0] f_r [3];
  logic [1:0] mstep_r;
  logic [DEN_W-1:0] pa_r;           // |x-bj|*|x-bk|
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic neg_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [1:0] st_r;
  logic signed [31:0] res_r;

  logic signed [VAL_W-1:0] rd_abs, rd_ord;
  logic wr_en;
  assign wr_en = (state_r == S_IDLE) && start && (in_func == FN_WRITE);

  tqi_table_ram u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(in_entry_index[IDX_W-1:0]),
    .wr_abs(in_abscissa_value), .wr_ord(in_ordinate_value),
    .rd_addr(rd_addr), .rd_abs(rd_abs), .rd_ord(rd_ord)
  );

  logic div_start, div_done;
  logic [QUO_W-1:0] quo;
  div_req_t dreq;
  assign dreq.num = num_r;
  assign dreq.den = den_r;
  assign div_start = (state_r == S_DIV);
  tqi_divider u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .req(dreq),
                     .done(div_done), .quo(quo));

  assign mid = k1_r + ((k2_r - k1_r) >> 1);

  // search and triple decisions
  logic too_few, x_lt, x_gt, hit, mid_lt, narrow, rep;
  assign too_few = (n < CNT_W'(3));
  assign x_lt    = (x_r < rd_abs);
  assign x_gt    = (x_r > rd_abs);
  assign hit     = (rd_abs == x_r);
  assign mid_lt  = (rd_abs < x_r);
  assign narrow  = ((k2_r - k1_r) <= IDX_W'(1));
  assign rep     = (b_r[0] == b_r[1]) || (b_r[0] == rd_abs) || (b_r[1] == rd_abs);

  // term indices j,k for term ti
  logic [1:0] tj, tk;
  always_comb begin
    case (ti_r)
      2'd0:    begin tj = 2'd1; tk = 2'd2; end
      2'd1:    begin tj = 2'd0; tk = 2'd2; end
      default: begin tj = 2'd0; tk = 2'd1; end
    endcase
  end
  logic signed [32:0] dxj, dxk, dij, dik;
  assign dxj = 33'(x_r) - 33'(b_r[tj]);
  assign dxk = 33'(x_r) - 33'(b_r[tk]);
  assign dij = 33'(b_r[ti_r]) - 33'(b_r[tj]);
  assign dik = 33'(b_r[ti_r]) - 33'(b_r[tk]);
  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  logic [31:0] mf;                  // |f_ti|
  assign mf = f_r[ti_r][31] ? 32'(-f_r[ti_r]) : f_r[ti_r];

  // multiplier operands, one product per step
  logic [32:0] ma, mb;
  logic [65:0] mp;
  always_comb begin
    case (mstep_r)
      2'd0:    begin ma = mag33(dxj); mb = mag33(dxk); end
      2'd1:    begin ma = mag33(dij); mb = mag33(dik); end
      2'd2:    begin ma = pa_r[32:0];  mb = {1'b0, mf}; end
      default: begin ma = pa_r[65:33]; mb = {1'b0, mf}; end
    endcase
    mp = ma * mb;
  end

  always_comb begin
    state_nxt = state_r;
    rd_addr = '0;                   // idle reads entry 0 ahead of a query
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = (in_func == FN_QUERY && !too_few) ? S_LO : S_OUT;
      S_LO:    begin
        rd_addr = IDX_W'(n - CNT_W'(1));
        state_nxt = x_lt ? S_TRIP : S_HI;
      end
      S_HI:    state_nxt = x_gt ? S_TRIP : S_PROBE;
      S_PROBE: begin
        if (narrow) state_nxt = S_TRIP;
        else begin
          rd_addr = mid;
          state_nxt = S_PWAIT;
        end
      end
      S_PWAIT: state_nxt = hit ? S_OUT : S_PROBE;
      S_TRIP:  begin
        rd_addr = k1_r + IDX_W'(ti_r);
        if (ti_r == 2'd3) state_nxt = rep ? S_OUT : S_MUL;
      end
      S_MUL:   if (mstep_r == 2'd3) state_nxt = S_DIV;
      S_DIV:   state_nxt = S_DWAIT;
      S_DWAIT: if (div_done) state_nxt = S_SUM;
      S_SUM:   state_nxt = (ti_r == 2'd2) ? S_SAT : S_MUL;
      S_SAT:   state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      piu_r <= CNT_W'(15);
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) piu_r <= cfg_data;
    end
  end

  // datapath: no reset needed, control decides what is used
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (start) begin
        x_r <= in_query_x;
        res_r <= '0;
        st_r <= (in_func == FN_QUERY && too_few) ? ST_FEW : ST_OK;
      end
      S_LO: begin
        k1_r <= '0;                 // below the table: first triple
        ti_r <= '0;
      end
      S_HI: begin
        k1_r <= x_gt ? IDX_W'(n - CNT_W'(3)) : '0;   // above: last triple
        k2_r <= IDX_W'(n - CNT_W'(1));
      end
      S_PROBE: begin
        // search ended at the top end: last triple
        if (narrow && k2_r == IDX_W'(n - CNT_W'(1))) k1_r <= IDX_W'(n - CNT_W'(3));
      end
      S_PWAIT: begin
        if (hit) res_r <= rd_ord;
        else if (mid_lt) k1_r <= mid;
        else k2_r <= mid;
      end
      S_TRIP: begin
        ti_r <= ti_r + 2'd1;        // wraps to 0 for the first term
        if (ti_r != 2'd0) begin
          b_r[ti_r - 2'd1] <= rd_abs;
          f_r[ti_r - 2'd1] <= rd_ord;
        end
        if (ti_r == 2'd3) begin
          if (rep) st_r <= ST_REP;
          mstep_r <= '0;
          acc_r <= '0;
        end
      end
      S_MUL: begin
        mstep_r <= mstep_r + 2'd1;
        case (mstep_r)
          2'd0: begin
            pa_r <= mp;
            neg_r <= f_r[ti_r][31] ^ dxj[32] ^ dxk[32] ^ dij[32] ^ dik[32];
          end
          2'd1: den_r <= mp;
          2'd2: num_r <= NUM_W'(mp);
          default: num_r <= num_r + (NUM_W'(mp) << 33);
        endcase
      end
      S_SUM: begin
        acc_r <= neg_r ? acc_r - $signed(ACC_W'(quo)) : acc_r + $signed(ACC_W'(quo));
        ti_r <= ti_r + 2'd1;
      end
      S_SAT: begin
        if (acc_r > SAT_HI) begin
          res_r <= 32'sh7FFFFFFF; st_r <= ST_SAT;
        end else if (acc_r < SAT_LO) begin
          res_r <= 32'sh80000000; st_r <= ST_SAT;
        end else res_r <= acc_r[31:0];
      end
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign out_valid = (state_r == S_OUT);
  assign out_result_value = res_r;
  assign out_status = st_r;
endmodule
`default_nettype wire
